>>> hdl/ahht_pkg.sv
// shared widths, codes and types of the anomaly health hysteresis tracker
package ahht_pkg;

	localparam int VW = 24;
	localparam int CW = 24;
	localparam int LIMIT_W = 23;
	localparam int BAND_W = 23;
	localparam int IDX_W = 3;
	localparam int SW = VW + 8;
	localparam int PW = SW + 12;
	localparam int FRAC = 12;
	localparam int TW = ((VW > CW) ? VW : CW) + 2;

	localparam logic signed [SW-1:0] HALF_Q = SW'(2048);
	localparam logic signed [PW-1:0] DECAY_Q = PW'(3482);
	localparam logic signed [PW-1:0] ROUND_Q = PW'(2048);
	localparam logic [SW-1:0] VMAX = SW'((64'd1 << (VW - 1)) - 64'd1);

	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(409600);
	localparam logic [BAND_W-1:0] BAND_RST = BAND_W'(40960);
	localparam logic signed [VW-1:0] HEALTH_RST = VW'(409600 / 2);

	typedef enum logic [1:0] {
		ST_OFF = 2'd0,
		ST_ON  = 2'd1,
		ST_ERR = 2'd2
	} run_state_t;

	typedef enum logic [1:0] {
		MODE_ACCUM  = 2'd0,
		MODE_FEAT_A = 2'd1,
		MODE_FEAT_B = 2'd2,
		MODE_HOLD   = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_GATE   = 3'd0,
		REG_LIMIT  = 3'd1,
		REG_LEVEL  = 3'd2,
		REG_BAND   = 3'd3,
		REG_MODE   = 3'd4,
		REG_MODEL  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] gate_threshold;
		logic [LIMIT_W-1:0]   health_limit;
		logic signed [CW-1:0] abnormal_level;
		logic [BAND_W-1:0]    switch_band;
		mode_t                display_mode;
		logic                 model_ready;
	} cfg_t;

	typedef struct packed {
		logic signed [VW-1:0] health;
		logic [1:0]           machine_state;
		logic                 alarm;
		logic                 active;
	} res_t;

endpackage

>>> hdl/ahht_if.sv
// request channels of the tracker: input items and result items
interface ahht_in_if;
	import ahht_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [VW-1:0] score;
	logic signed [VW-1:0] feature_a;
	logic signed [VW-1:0] feature_b;

	modport source (output valid, output score, output feature_a, output feature_b,
		input ready);
	modport sink (input valid, input score, input feature_a, input feature_b,
		output ready);
endinterface

interface ahht_out_if;
	import ahht_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [VW-1:0] health;
	logic [1:0]           machine_state;
	logic                 alarm;
	logic                 active;

	modport source (output valid, output health, output machine_state, output alarm,
		output active, input ready);
	modport sink (input valid, input health, input machine_state, input alarm,
		input active, output ready);
endinterface

>>> hdl/ahht_cfg_regs.sv
// configuration register file of the tracker
module ahht_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ahht_pkg::IDX_W-1:0] cfg_index,
	input  logic [ahht_pkg::CW-1:0]  cfg_data,
	output ahht_pkg::cfg_t           cfg
);
	import ahht_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_threshold <= '0;
			cfg_q.health_limit   <= LIMIT_RST;
			cfg_q.abnormal_level <= '0;
			cfg_q.switch_band    <= BAND_RST;
			cfg_q.display_mode   <= MODE_ACCUM;
			cfg_q.model_ready    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GATE:  cfg_q.gate_threshold <= $signed(cfg_data);
				REG_LIMIT: cfg_q.health_limit   <= cfg_data[LIMIT_W-1:0];
				REG_LEVEL: cfg_q.abnormal_level <= $signed(cfg_data);
				REG_BAND:  cfg_q.switch_band    <= cfg_data[BAND_W-1:0];
				REG_MODE:  cfg_q.display_mode   <= mode_t'(cfg_data[1:0]);
				REG_MODEL: cfg_q.model_ready    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/ahht_health_calc.sv
// next health value: leaky accumulate, feature copy or hold, then clamp
module ahht_health_calc (
	input  logic signed [ahht_pkg::VW-1:0] health_cur,
	input  logic signed [ahht_pkg::VW-1:0] score,
	input  logic signed [ahht_pkg::VW-1:0] feature_a,
	input  logic signed [ahht_pkg::VW-1:0] feature_b,
	input  ahht_pkg::mode_t                mode,
	input  logic [ahht_pkg::LIMIT_W-1:0]   health_limit,
	output logic signed [ahht_pkg::VW-1:0] health_new
);
	import ahht_pkg::*;

	logic signed [SW-1:0] h_x;
	logic signed [SW-1:0] sc_x;
	logic signed [SW-1:0] fa_x;
	logic signed [SW-1:0] fb_x;
	logic signed [SW-1:0] sum;
	logic signed [PW-1:0] prod;
	logic signed [SW-1:0] leak;
	logic signed [SW-1:0] raw;
	logic [SW-1:0]        lim_u;
	logic signed [SW-1:0] lim_x;

	assign h_x  = SW'(health_cur);
	assign sc_x = SW'(score);
	assign fa_x = SW'(feature_a);
	assign fb_x = SW'(feature_b);

	// score times 50 when positive, times 2 otherwise
	always_comb begin
		if (sc_x > 0) begin
			sum = h_x + (sc_x <<< 5) + (sc_x <<< 4) + (sc_x <<< 1) + HALF_Q;
		end else begin
			sum = h_x + (sc_x <<< 1) - HALF_Q;
		end
	end

	// times 0.85, rounded to nearest with floor shift
	assign prod = PW'(sum) * DECAY_Q + ROUND_Q;
	assign leak = prod[FRAC +: SW];

	always_comb begin
		case (mode)
			MODE_ACCUM:  raw = leak;
			MODE_FEAT_A: raw = (fa_x <<< 3) + (fa_x <<< 1);
			MODE_FEAT_B: raw = (fb_x <<< 3) + (fb_x <<< 1);
			default:     raw = h_x;
		endcase
	end

	assign lim_u = (SW'(health_limit) > VMAX) ? VMAX : SW'(health_limit);
	assign lim_x = $signed(lim_u);

	always_comb begin
		if (raw > lim_x) begin
			health_new = VW'(lim_x);
		end else if (raw < -lim_x) begin
			health_new = VW'(-lim_x);
		end else begin
			health_new = VW'(raw);
		end
	end

endmodule

>>> hdl/ahht_core.sv
// health and run state registers with the on/error/off hysteresis machine
module ahht_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic signed [ahht_pkg::VW-1:0] score,
	input  logic signed [ahht_pkg::VW-1:0] feature_a,
	input  logic signed [ahht_pkg::VW-1:0] feature_b,
	input  ahht_pkg::cfg_t                 cfg,
	output ahht_pkg::res_t                 res
);
	import ahht_pkg::*;

	logic signed [VW-1:0] health_q;
	run_state_t           state_q;
	run_state_t           state_d;
	logic signed [VW-1:0] health_calc;
	logic signed [VW-1:0] health_d;
	logic                 gate_ok;
	logic                 active;
	logic signed [TW-1:0] h_t;
	logic signed [TW-1:0] lo_t;
	logic signed [TW-1:0] hi_t;

	ahht_health_calc u_calc (
		.health_cur  (health_q),
		.score       (score),
		.feature_a   (feature_a),
		.feature_b   (feature_b),
		.mode        (cfg.display_mode),
		.health_limit(cfg.health_limit),
		.health_new  (health_calc)
	);

	assign gate_ok = TW'(feature_a) >= TW'(cfg.gate_threshold);
	assign active  = cfg.model_ready && gate_ok;
	assign health_d = active ? health_calc : health_q;

	assign h_t  = TW'(health_calc);
	assign lo_t = TW'(cfg.abnormal_level) - $signed(TW'(cfg.switch_band));
	assign hi_t = TW'(cfg.abnormal_level) + $signed(TW'(cfg.switch_band));

	// next state
	always_comb begin
		state_d = state_q;
		if (cfg.model_ready) begin
			if (!gate_ok) begin
				state_d = ST_OFF;
			end else begin
				case (state_q)
					ST_ON: begin
						if (h_t < lo_t) state_d = ST_ERR;
					end
					ST_ERR: begin
						if (h_t > hi_t) state_d = ST_ON;
					end
					default: state_d = ST_ON;
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		res.health        = health_d;
		res.machine_state = state_d;
		res.alarm         = (state_q == ST_ERR);
		res.active        = active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= HEALTH_RST;
			state_q  <= ST_OFF;
		end else if (fire) begin
			health_q <= health_d;
			state_q  <= state_d;
		end
	end

endmodule

>>> hdl/anomaly_health_hysteresis_tracker_top.sv
// top level of the anomaly health hysteresis tracker
// Takes one request per clock unless a held result stalls the pipe, and gives
// one result per request: the request is captured in an input register, the
// health update (one 32x12 constant multiply for the leaky mode, then the clamp)
// and the state machine step run from it and land in the result register.
// A new request can follow every cycle while results are taken; health and state
// feedback closes inside the core. Configuration registers take effect on the
// next request and should be written only while no request is in flight.
module anomaly_health_hysteresis_tracker_top (
	input  logic                       clk,
	input  logic                       arst_n,
	ahht_in_if.sink                    samples,
	ahht_out_if.source                 results,
	input  logic                       cfg_we,
	input  logic [ahht_pkg::IDX_W-1:0] cfg_index,
	input  logic [ahht_pkg::CW-1:0]    cfg_data
);
	import ahht_pkg::*;

	cfg_t cfg;
	res_t res;

	logic                 v_s1;
	logic signed [VW-1:0] score_s1;
	logic signed [VW-1:0] fa_s1;
	logic signed [VW-1:0] fb_s1;
	logic                 v_s2;
	res_t                 res_s2;
	logic                 adv;
	logic                 fire;
	logic                 take;

	ahht_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign adv  = !v_s2 || results.ready;
	assign fire = v_s1 && adv;
	assign samples.ready = !v_s1 || adv;
	assign take = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (samples.ready) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			score_s1 <= samples.score;
			fa_s1    <= samples.feature_a;
			fb_s1    <= samples.feature_b;
		end
	end

	ahht_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.score    (score_s1),
		.feature_a(fa_s1),
		.feature_b(fb_s1),
		.cfg      (cfg),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign results.valid         = v_s2;
	assign results.health        = res_s2.health;
	assign results.machine_state = res_s2.machine_state;
	assign results.alarm         = res_s2.alarm;
	assign results.active        = res_s2.active;

	logic signed [TW-1:0] health_t;
	logic signed [TW-1:0] limit_t;

	assign health_t = TW'(results.health);
	assign limit_t  = $signed(TW'(cfg.health_limit));

	a_active_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.active) |-> (results.machine_state != ST_OFF))
		else $error("active result reports state off");

	a_health_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.active) |-> ((health_t <= limit_t) && (health_t >= -limit_t)))
		else $error("active result health outside limit");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !results.ready) |-> !samples.ready)
		else $error("request taken while both stages are held");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> v_s2)
		else $error("processed request did not reach the result register");

endmodule
